[sv/pqs_pkg.sv]
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types and constants of the periodic query scheduler: request and
// response payloads, status and opcode codes, the sort key held by each cell.
// ----------------------------------------------------------------------------
package pqs_pkg;

    localparam int PQS_CAPACITY = 1024;
    localparam int ID_W         = 16;
    localparam int PERIOD_W     = 16;
    localparam int DUE_W        = 48;

    typedef enum logic
    {
        OP_REGISTER = 1'b0,
        OP_POP      = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        STATUS_REGISTERED = 2'd0,
        STATUS_EMITTED    = 2'd1,
        STATUS_FULL       = 2'd2,
        STATUS_EMPTY      = 2'd3
    } status_t;

    typedef struct packed
    {
        opcode_t               opcode;
        logic [ID_W-1:0]       query_id;
        logic [PERIOD_W-1:0]   period;
    } req_t;

    typedef struct packed
    {
        status_t               status;
        logic [ID_W-1:0]       emitted_id;
        logic [DUE_W-1:0]      due_time;
    } rsp_t;

    // ordering key: due time first, then identifier, then period
    typedef struct packed
    {
        logic [DUE_W-1:0]      due;
        logic [ID_W-1:0]       id;
        logic [PERIOD_W-1:0]   per;
    } key_t;

    localparam int KEY_W = $bits(key_t);

    // per-cycle command to every cell of the row
    typedef struct packed
    {
        logic                  shift_en;
        logic                  insert_en;
    } cell_ctrl_t;

endpackage

[sv/periodic_query_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// periodic_query_scheduler_unit
// Priority scheduler of periodic queries built as a sorted row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, payload req): opcode OP_REGISTER stores
//   query_id with its period, first due at the period; OP_POP asks for the
//   query with the least due time (ties by lower id, then lower period).
//   rsp channel (rsp_valid/rsp_ready, payload rsp): exactly one response per
//   request, in request order: registered, emitted (id and due time), store
//   full (request dropped) or store empty.
//   The response is written into a two-entry queue at the edge that takes the
//   request and is visible the next cycle if no older response waits ahead.
//   A register or a successful pop is accepted in ST_IDLE, then passes
//   through ST_INSERT, in which the new or re-scheduled key is broadcast to
//   every cell and the row shifts in one step (req_ready low); full or empty
//   stays in ST_IDLE. Each cell's key compare picks keep, new or left key.
//   Reset empties the store at once; no clearing pass is needed.
//   When rsp_ready stays low the queue holds up to two responses, then
//   req_ready drops until a response is taken.
// ----------------------------------------------------------------------------
module periodic_query_scheduler_unit
    import pqs_pkg::*;
#(
    parameter int CAPACITY = PQS_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'b01,
        ST_INSERT = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    key_t             ins_key_reg;
    key_t             ins_key_next;

    key_t             cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_le;
    cell_ctrl_t       ctrl;

    logic             req_fire;
    logic             is_pop;
    logic             full;
    logic             empty;
    key_t             head;
    logic [DUE_W:0]   due_sum;
    logic [DUE_W-1:0] next_due;
    rsp_t             result;
    logic             q_room;

    assign req_fire = req_valid && req_ready;
    assign is_pop   = req.opcode == OP_POP;
    assign full     = count_reg == CAP_C;
    assign empty    = count_reg == '0;
    assign head     = cell_key[0];
    assign req_ready = (state_reg == ST_IDLE) && q_room;

    // re-schedule time of the head, saturating at the top of the range
    assign due_sum  = {1'b0, head.due} + {{(DUE_W + 1 - PERIOD_W){1'b0}}, head.per};
    assign next_due = due_sum[DUE_W] ? {DUE_W{1'b1}} : due_sum[DUE_W-1:0];

    // response formed at accept time
    always_comb
    begin
        result.status     = STATUS_REGISTERED;
        result.emitted_id = '0;
        result.due_time   = '0;
        if (is_pop)
        begin
            if (empty)
            begin
                result.status = STATUS_EMPTY;
            end
            else
            begin
                result.status     = STATUS_EMITTED;
                result.emitted_id = head.id;
                result.due_time   = head.due;
            end
        end
        else if (full)
        begin
            result.status = STATUS_FULL;
        end
    end

    // row commands: shift out the head on pop, broadcast insert next cycle
    assign ctrl.shift_en  = req_fire && is_pop && !empty;
    assign ctrl.insert_en = state_reg == ST_INSERT;

    // sequencer, fill level and key to insert
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ins_key_next = ins_key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (is_pop && !empty)
                    begin
                        state_next   = ST_INSERT;
                        count_next   = count_reg - CNT_W'(1);
                        ins_key_next = '{due: next_due, id: head.id, per: head.per};
                    end
                    else if (!is_pop && !full)
                    begin
                        state_next   = ST_INSERT;
                        ins_key_next = '{due: {{(DUE_W - PERIOD_W){1'b0}}, req.period},
                                         id: req.query_id, per: req.period};
                    end
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
                count_next = count_reg + CNT_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_key_reg <= ins_key_next;
    end

    // sorted row of cells, head at index 0
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        key_t left_key;
        logic left_le;
        key_t right_key;

        if (g == 0)
        begin : g_first
            assign left_key = ins_key_reg;
            assign left_le  = 1'b1;
        end
        else
        begin : g_rest
            assign left_key = cell_key[g-1];
            assign left_le  = cell_le[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_key = cell_key[g];
        end
        else
        begin : g_inner
            assign right_key = cell_key[g+1];
        end

        pqs_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .new_key   (ins_key_reg),
            .left_key  (left_key),
            .left_le   (left_le),
            .right_key (right_key),
            .key       (cell_key[g]),
            .le        (cell_le[g])
        );
    end

    // response queue
    pqs_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_fire),
        .push_data (result),
        .room      (q_room),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // fill level never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("fill level above capacity");

    // a pop from a non-empty store drops the level and schedules a re-insert
    a_pop_reinsert: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && is_pop && !empty |=>
            state_reg == ST_INSERT && count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not schedule re-insert");

    // an insert cycle adds one entry and returns to idle
    a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |=>
            state_reg == ST_IDLE && count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert cycle did not complete");

    // row stays sorted at its head
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && count_reg >= CNT_W'(2) |->
            KEY_W'(cell_key[0]) <= KEY_W'(cell_key[1]))
        else $error("head of row out of order");

endmodule

[sv/pqs_cell.sv]
// ----------------------------------------------------------------------------
// pqs_cell
// One slot of the sorted row. Holds one key, compares it with the key being
// inserted and either keeps it, takes the new key, or takes a neighbor's key.
// ----------------------------------------------------------------------------
module pqs_cell
    import pqs_pkg::*;
#(
    parameter int CNT_W = 11,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  key_t             new_key,
    input  key_t             left_key,
    input  logic             left_le,
    input  key_t             right_key,
    output key_t             key,
    output logic             le
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    key_t             key_reg;
    key_t             key_next;
    logic             occupied;
    logic [KEY_W-1:0] own_bits;
    logic [KEY_W-1:0] new_bits;

    // slot is live when it sits below the fill level
    assign occupied = IDX_C < count;
    assign own_bits = key_reg;
    assign new_bits = new_key;
    assign le       = occupied && (own_bits <= new_bits);

    // keep, take the new key, or take the neighbor's key
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.shift_en)
        begin
            key_next = right_key;
        end
        else if (ctrl.insert_en && !le)
        begin
            key_next = left_le ? new_key : left_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

[sv/pqs_out_queue.sv]
// ----------------------------------------------------------------------------
// pqs_out_queue
// Two-entry response queue between the scheduler core and the response
// channel, so a new request can be taken while a response still waits.
// ----------------------------------------------------------------------------
module pqs_out_queue
    import pqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rsp_t push_data,
    output logic room,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    rsp_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop       = rsp_valid && rsp_ready;
    assign rsp_valid = cnt_reg != 2'd0;
    assign room      = cnt_reg != 2'd2;
    assign rsp       = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // response storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic query scheduler. Drives register and
// pop requests over the valid/ready request channel, keeps its own schedule
// of keys (due time, id, period) to work out each response, and checks
// every response field by field in request order. Covers the empty and full
// store, ties, period zero, deep stores and long response back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import pqs_pkg::*;

    localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // idle rates in percent and long-hold control of the response side
    int req_idle_pct = 0;
    int rsp_idle_pct = 0;
    int hold_len     = 0;
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    // schedule mirror of the block
    key_t model_key [PQS_CAPACITY];
    int   model_count       = 0;
    int   dropped_registers = 0;

    rsp_t pending_responses [$];
    int   mismatch_count = 0;

    periodic_query_scheduler_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // applies one request to the mirror and returns the response it causes
    function automatic rsp_t schedule_request(req_t r);
        rsp_t out;
        key_t head;
        int   best;
        out = '0;
        if (r.opcode == OP_REGISTER)
        begin
            if (model_count >= PQS_CAPACITY)
            begin
                out.status = STATUS_FULL;
                dropped_registers++;
            end
            else
            begin
                model_key[model_count] = {{(DUE_W-PERIOD_W){1'b0}}, r.period,
                                          r.query_id, r.period};
                model_count++;
                out.status = STATUS_REGISTERED;
            end
        end
        else if (model_count == 0)
        begin
            out.status = STATUS_EMPTY;
        end
        else
        begin
            // least key wins: due time, then id, then period
            best = 0;
            for (int i = 1; i < model_count; i++)
            begin
                if (model_key[i] < model_key[best])
                    best = i;
            end
            head           = model_key[best];
            out.status     = STATUS_EMITTED;
            out.emitted_id = head.id;
            out.due_time   = head.due;
            // reschedule with saturation at the top of the due range
            if (head.due > DUE_MAX - head.per)
                head.due = DUE_MAX;
            else
                head.due = head.due + head.per;
            model_key[best] = head;
        end
        return out;
    endfunction

    function automatic req_t request_of(opcode_t op, logic [ID_W-1:0] id,
                                        logic [PERIOD_W-1:0] per);
        req_t r;
        r.opcode   = op;
        r.query_id = id;
        r.period   = per;
        return r;
    endfunction

    // random request, ids and periods often small so that ties are common
    function automatic req_t random_request(int reg_pct);
        req_t r;
        int   roll;
        r.opcode   = ($urandom_range(0, 99) < reg_pct) ? OP_REGISTER : OP_POP;
        r.query_id = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7))
                                                 : 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 40)
            r.period = 16'($urandom_range(1, 4));
        else if (roll < 45)
            r.period = 16'hFFFF;
        else
            r.period = 16'($urandom_range(1, 65535));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want,
                                   longint unsigned got);
        if (mismatch_count < 40)
            $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // offers one request and waits until it is taken
    task automatic send_request(req_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // stops offering and waits until every response has come back
    task automatic wait_for_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // response side: random idling, or a long hold when asked for
    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    // response check against the oldest pending, then prediction of new requests
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    report_mismatch("response with none pending, status", 0, rsp.status);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (rsp.status != want.status)
                        report_mismatch("status", want.status, rsp.status);
                    if (rsp.emitted_id != want.emitted_id)
                        report_mismatch("emitted_id", want.emitted_id, rsp.emitted_id);
                    if (rsp.due_time != want.due_time)
                        report_mismatch("due_time", want.due_time, rsp.due_time);
                end
            end
            if (req_valid && req_ready)
                pending_responses.insert(pending_responses.size(), schedule_request(req));
        end
    end

    // empty pop, field extremes, ties by id, duplicates
    task automatic test_directed();
        send_request(request_of(OP_POP, 16'hFFFF, 16'hFFFF));
        send_request(request_of(OP_REGISTER, 16'd5, 16'd10));
        send_request(request_of(OP_REGISTER, 16'd3, 16'd10));
        send_request(request_of(OP_REGISTER, 16'd9, 16'd4));
        send_request(request_of(OP_REGISTER, 16'd9, 16'd6));
        send_request(request_of(OP_REGISTER, 16'h0000, 16'hFFFF));
        send_request(request_of(OP_REGISTER, 16'hFFFF, 16'd1));
        send_request(request_of(OP_REGISTER, 16'd2, 16'd3));
        send_request(request_of(OP_REGISTER, 16'd2, 16'd3));
        send_request(request_of(OP_REGISTER, 16'hAAAA, 16'h8000));
        send_request(request_of(OP_REGISTER, 16'h5555, 16'h7FFF));
        repeat (14)
            send_request(request_of(OP_POP, 16'h0000, 16'h0000));
    endtask

    task automatic test_random_mix(int count, int reg_pct);
        repeat (count)
            send_request(random_request(reg_pct));
    endtask

    // hold responses off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_len = 80;
        hold_token++;
        repeat (12)
            send_request(random_request(60));
        wait_for_drain();
    endtask

    // mostly registers until the store is nearly full
    task automatic test_fill_store();
        while (model_count < PQS_CAPACITY - 3)
            send_request(random_request(95));
    endtask

    // period zero stays due at zero; ties at zero go to the lower id
    task automatic test_period_zero();
        send_request(request_of(OP_REGISTER, 16'h0042, 16'h0000));
        send_request(request_of(OP_POP, 16'h1234, 16'h0001));
        send_request(request_of(OP_POP, 16'h0000, 16'h0000));
        send_request(request_of(OP_REGISTER, 16'h0041, 16'h0000));
        send_request(request_of(OP_POP, 16'h0000, 16'h0000));
        send_request(request_of(OP_POP, 16'hFFFF, 16'hFFFF));
    endtask

    // registers into a full store are dropped
    task automatic test_store_full();
        while (dropped_registers < 6)
            send_request(random_request(80));
        send_request(request_of(OP_POP, 16'h0000, 16'h0000));
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        req_idle_pct = 14;
        rsp_idle_pct = 47;
        test_directed();
        test_random_mix(250, 85);
        wait_for_drain();

        req_idle_pct = 47;
        rsp_idle_pct = 14;
        test_random_mix(250, 85);
        wait_for_drain();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        test_backpressure();
        test_fill_store();
        test_period_zero();
        test_store_full();

        wait_for_drain();
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
